// File: rtl/snn_pkg.sv
// Package with shared types, constants and arithmetic helpers for the spiking network tick.
package snn_pkg;

  // Default network size and synapse fan-out.
  localparam int NEURONS_DEF = 16;
  localparam int FANOUT_DEF  = 4;
  // At most this many neurons are reported and updated in one tick.
  localparam int REPORT_MAX  = 16;

  // Actions carried by an input transaction.
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_STIM   = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_IGNORE = 2'd3;

  // Configuration register indexes and reset values.
  localparam int          PADDR_W          = 4;
  localparam logic [1:0]  REG_ACTIVE       = 2'd0;
  localparam logic [1:0]  REG_REFRACT      = 2'd1;
  localparam logic [1:0]  REG_THRESH       = 2'd2;
  localparam logic [4:0]  ACTIVE_RESET     = 5'd10;
  localparam logic [7:0]  REFRACT_RESET    = 8'd5;
  localparam logic [10:0] THRESH_RESET     = 11'd10;

  // Synapse amounts in Q11.8.
  localparam logic signed [19:0] AMT_EXC = 20'sd1536;
  localparam logic signed [19:0] AMT_INH = -20'sd512;

  // Reciprocals for exact floor division by multiply and shift.
  localparam logic [24:0] RECIP6 = 25'd22369622;
  localparam int          SH6    = 27;
  localparam logic [24:0] RECIP5 = 25'd6710887;
  localparam int          SH5    = 25;

  // Tick sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REP,
    ST_FCHK,
    ST_FOUT,
    ST_SRCH,
    ST_HALF,
    ST_U0,
    ST_U1,
    ST_U2,
    ST_U3
  } state_t;

  // Saturate a wide value to the signed 20-bit range.
  function automatic logic signed [19:0] sat20(input logic signed [23:0] x);
    logic signed [19:0] r;
    if (x > 24'sd524287) begin
      r = 20'sd524287;
    end else if (x < -24'sd524288) begin
      r = -20'sd524288;
    end else begin
      r = x[19:0];
    end
    return r;
  endfunction

  // Round a Q11.8 value to an integer, ties away from zero.
  function automatic logic signed [12:0] round_q8(input logic signed [19:0] v);
    logic [20:0] mag;
    logic [12:0] q;
    logic signed [12:0] r;
    mag = v[19] ? 21'(-{v[19], v}) : 21'({1'b0, v});
    q = 13'((mag + 21'd128) >> 8);
    r = v[19] ? -$signed(q) : $signed(q);
    return r;
  endfunction

endpackage

// File: rtl/snn_ram.sv
// Generic single-port-write, registered-read RAM.
module snn_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/spiking_neuron_network_tick_top.sv
// Top level of the spiking neuron network: command port, register port and tick sequencer.
// Load and stimulus transactions complete in the accept cycle; busy stays low.
// A tick with n active neurons reports one result per cycle for each of them, then walks each
// neuron: one that fires reads its synapses, and searches for a source if none is valid, over the
// synapse RAM read port; states U0 to U3 then update each neuron. Results cannot be stalled.
// Synchronous reset restores register defaults and clears all neuron state and synapse valid bits.
module spiking_neuron_network_tick_top #(
  parameter int NEURONS = snn_pkg::NEURONS_DEF,
  parameter int FANOUT  = snn_pkg::FANOUT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic [3:0]                   neuron_index,
  input  logic [1:0]                   slot,
  input  logic [3:0]                   target,
  input  logic                         target_valid,
  input  logic                         excitatory,
  input  logic [7:0]                   stim_amount,
  output logic                         result_strobe,
  output logic [3:0]                   out_neuron,
  output logic signed [11:0]           voltage_out,
  output logic                         overflow,
  output logic                         last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [snn_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int NW    = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int FW    = (FANOUT > 1) ? $clog2(FANOUT) : 1;
  localparam int SD    = NEURONS * FANOUT;
  localparam int AW    = $clog2(SD);
  localparam int RL    = (NEURONS < snn_pkg::REPORT_MAX) ? NEURONS : snn_pkg::REPORT_MAX;
  localparam logic [FW-1:0] KLAST = FW'(FANOUT - 1);

  // Configuration registers.
  logic [4:0]  active_neurons;
  logic [7:0]  refractory_ticks;
  logic [10:0] fire_threshold;

  // Neuron state.
  logic signed [19:0] vmem [NEURONS];
  logic signed [19:0] imem [NEURONS];
  logic [NEURONS-1:0] rflag;
  logic [7:0]         rcnt [NEURONS];
  logic [SD-1:0]      syn_wr;

  // Sequencer.
  snn_pkg::state_t state, state_next;
  logic [4:0]    i, j, jn;
  logic [FW-1:0] k, kn;
  logic          sent;
  logic [4:0]    n;

  // Synapse RAM interface.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, rd_addr;
  logic [5:0]    ram_wdata, ram_rdata, syn;
  logic          wv_q;

  // Update datapath registers.
  logic [24:0] m6;
  logic [21:0] m5;
  logic        neg6, neg5;
  logic [22:0] q6;
  logic [49:0] prod;
  logic [24:0] mul_a, mul_b;
  logic [49:0] mul_p;

  logic accept;
  logic signed [19:0] v_rd, in_rd;
  logic [NW-1:0] vaddr, iaddr;
  logic fire, sent_now, match, syn_dest_ok;
  logic signed [19:0] amt, in_add;
  logic signed [12:0] rnd;
  logic signed [19:0] v_half;
  logic signed [19:0] v_upd, in_upd;
  logic [7:0] cnt_upd;
  logic       flag_upd;
  logic [19:0] q5;

  assign pready = 1'b1;
  assign accept = start && !busy;

  // Effective active count.
  assign n = (32'(active_neurons) > RL) ? 5'(RL) : active_neurons;

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      snn_pkg::REG_ACTIVE:  prdata = {27'd0, active_neurons};
      snn_pkg::REG_REFRACT: prdata = {24'd0, refractory_ticks};
      snn_pkg::REG_THRESH:  prdata = {21'd0, fire_threshold};
      default:              prdata = 32'd0;
    endcase
  end

  // Synapse table storage.
  snn_ram #(.WIDTH(6), .DEPTH(SD)) u_syn (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign ram_we    = accept && (action == snn_pkg::ACT_LOAD) &&
                     (32'(neuron_index) < NEURONS) && (32'(slot) < FANOUT);
  assign ram_waddr = AW'(32'(neuron_index) * FANOUT + 32'(slot));
  assign ram_wdata = {excitatory, target_valid, target};
  assign syn       = wv_q ? ram_rdata : 6'd0;

  // Next slot and source position of the reverse search.
  always_comb begin
    if (k == KLAST) begin
      kn = '0;
      jn = 5'(j + 5'd1);
    end else begin
      kn = FW'(k + 1'b1);
      jn = j;
    end
  end

  // Synapse read address.
  always_comb begin
    unique case (state)
      snn_pkg::ST_FOUT: rd_addr = (k == KLAST) ? '0 : AW'(32'(i) * FANOUT + 32'(k) + 1);
      snn_pkg::ST_SRCH: rd_addr = AW'(32'(jn) * FANOUT + 32'(kn));
      default:          rd_addr = AW'(32'(i) * FANOUT);
    endcase
  end

  // Neuron array read addresses.
  assign vaddr = (state == snn_pkg::ST_IDLE) ? NW'(neuron_index) : NW'(i);
  always_comb begin
    unique case (state)
      snn_pkg::ST_FOUT: iaddr = NW'(syn[3:0]);
      snn_pkg::ST_SRCH: iaddr = NW'(j);
      default:          iaddr = NW'(i);
    endcase
  end
  assign v_rd  = vmem[vaddr];
  assign in_rd = imem[iaddr];

  // Firing decisions and synapse input addition.
  assign fire     = ($signed(v_rd) >= $signed({1'b0, fire_threshold, 8'h00})) && !rflag[NW'(i)];
  assign sent_now = sent || syn[4];
  assign match    = syn[4] && (syn[3:0] == i[3:0]) && (j != i);
  assign syn_dest_ok = 32'(syn[3:0]) < NEURONS;
  assign amt      = syn[5] ? snn_pkg::AMT_EXC : snn_pkg::AMT_INH;
  assign in_add   = snn_pkg::sat20(24'(in_rd) + 24'(amt));

  // Report rounding.
  assign rnd = snn_pkg::round_q8(v_rd);

  // Voltage loss after firing: v - round(v/2) in integer units.
  always_comb begin
    logic [20:0] mag;
    logic [10:0] h;
    logic signed [23:0] d;
    mag = v_rd[19] ? 21'(-{v_rd[19], v_rd}) : 21'({1'b0, v_rd});
    h = 11'((mag + 21'd256) >> 9);
    d = $signed({5'd0, h, 8'd0});
    v_half = snn_pkg::sat20(24'(v_rd) - (v_rd[19] ? -d : d));
  end

  // Shared multiplier.
  always_comb begin
    if (state == snn_pkg::ST_U1) begin
      mul_a = m6;
      mul_b = snn_pkg::RECIP6;
    end else begin
      mul_a = 25'(m5);
      mul_b = snn_pkg::RECIP5;
    end
  end
  assign mul_p = 50'(mul_a) * 50'(mul_b);

  // Final leak update and refractory timer.
  assign q5 = prod[snn_pkg::SH5+19:snn_pkg::SH5];
  always_comb begin
    logic signed [23:0] dq;
    dq = $signed({1'b0, q6});
    v_upd  = snn_pkg::sat20(24'(v_rd) + (neg6 ? -dq : dq));
    in_upd = neg5 ? -$signed(q5) : $signed(q5);
    flag_upd = rflag[NW'(i)];
    cnt_upd  = rcnt[NW'(i)];
    if (cnt_upd >= refractory_ticks) begin
      cnt_upd  = 8'd0;
      flag_upd = 1'b0;
    end
    if (flag_upd && cnt_upd != 8'd255) begin
      cnt_upd = cnt_upd + 8'd1;
    end
  end

  // Result port.
  assign result_strobe = (state == snn_pkg::ST_REP);
  assign out_neuron    = i[3:0];
  assign voltage_out   = (rnd > 13'sd2047) ? 12'sd2047 :
                         (rnd < -13'sd2048) ? -12'sd2048 : rnd[11:0];
  assign overflow      = rnd > 13'sd999;
  assign last          = (i == 5'(n - 5'd1));
  assign busy          = (state != snn_pkg::ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= snn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      snn_pkg::ST_IDLE: if (accept && action == snn_pkg::ACT_TICK && n != 5'd0) begin
        state_next = snn_pkg::ST_REP;
      end
      snn_pkg::ST_REP: if (last) begin
        state_next = snn_pkg::ST_FCHK;
      end
      snn_pkg::ST_FCHK: begin
        if (i == n) begin
          state_next = snn_pkg::ST_U0;
        end else if (fire) begin
          state_next = snn_pkg::ST_FOUT;
        end
      end
      snn_pkg::ST_FOUT: if (k == KLAST) begin
        state_next = sent_now ? snn_pkg::ST_HALF : snn_pkg::ST_SRCH;
      end
      snn_pkg::ST_SRCH: begin
        if (match) begin
          state_next = snn_pkg::ST_HALF;
        end else if (jn == n) begin
          state_next = snn_pkg::ST_FCHK;
        end
      end
      snn_pkg::ST_HALF: state_next = snn_pkg::ST_FCHK;
      snn_pkg::ST_U0:   state_next = snn_pkg::ST_U1;
      snn_pkg::ST_U1:   state_next = snn_pkg::ST_U2;
      snn_pkg::ST_U2:   state_next = snn_pkg::ST_U3;
      snn_pkg::ST_U3:   state_next = (i == 5'(n - 5'd1)) ? snn_pkg::ST_IDLE : snn_pkg::ST_U0;
      default:          state_next = snn_pkg::ST_IDLE;
    endcase
  end

  // Update operands: leak numerator times five and input times four, as magnitudes.
  logic [24:0] m6_next;
  logic [21:0] m5_next;
  logic        neg6_next, neg5_next;
  always_comb begin
    logic signed [21:0] num;
    logic signed [23:0] num5;
    logic signed [21:0] in4;
    num  = 22'(-(22'(rnd) <<< 8)) + 22'(in_rd);
    num5 = 24'(num) * 24'sd5;
    neg6_next = num5[23];
    m6_next = 25'(neg6_next ? 25'(-{num5[23], num5}) : 25'({1'b0, num5})) + 25'd3;
    in4 = 22'(in_rd) <<< 2;
    neg5_next = in4[21];
    m5_next = neg5_next ? 22'(-in4) : 22'(in4);
  end

  // Datapath and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_neurons   <= snn_pkg::ACTIVE_RESET;
      refractory_ticks <= snn_pkg::REFRACT_RESET;
      fire_threshold   <= snn_pkg::THRESH_RESET;
      for (int e = 0; e < NEURONS; e++) begin
        vmem[e] <= '0;
        imem[e] <= '0;
        rcnt[e] <= '0;
      end
      rflag  <= '0;
      syn_wr <= '0;
      i      <= '0;
      j      <= '0;
      k      <= '0;
      sent   <= 1'b0;
      wv_q   <= 1'b0;
    end else begin
      wv_q <= syn_wr[rd_addr];
      // Register write transaction.
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[3:2])
          snn_pkg::REG_ACTIVE:  active_neurons   <= pwdata[4:0];
          snn_pkg::REG_REFRACT: refractory_ticks <= pwdata[7:0];
          snn_pkg::REG_THRESH:  fire_threshold   <= pwdata[10:0];
          default: ;
        endcase
      end
      unique case (state)
        snn_pkg::ST_IDLE: begin
          i <= '0;
          if (ram_we) begin
            syn_wr[ram_waddr] <= 1'b1;
          end
          if (accept && action == snn_pkg::ACT_STIM && 32'(neuron_index) < NEURONS) begin
            vmem[vaddr] <= snn_pkg::sat20(24'(v_rd) + $signed({8'd0, stim_amount, 8'd0}));
          end
        end
        snn_pkg::ST_REP: i <= last ? 5'd0 : 5'(i + 5'd1);
        snn_pkg::ST_FCHK: begin
          if (i == n) begin
            i <= '0;
          end else if (fire) begin
            k    <= '0;
            sent <= 1'b0;
          end else begin
            i <= 5'(i + 5'd1);
          end
        end
        snn_pkg::ST_FOUT: begin
          if (syn[4] && syn_dest_ok) begin
            imem[iaddr] <= in_add;
          end
          sent <= sent_now;
          if (k == KLAST) begin
            j <= '0;
            k <= '0;
          end else begin
            k <= kn;
          end
        end
        snn_pkg::ST_SRCH: begin
          if (match) begin
            imem[iaddr] <= in_add;
          end else if (jn == n) begin
            i <= 5'(i + 5'd1);
          end else begin
            j <= jn;
            k <= kn;
          end
        end
        snn_pkg::ST_HALF: begin
          vmem[vaddr]     <= v_half;
          rflag[NW'(i)]   <= 1'b1;
          rcnt[NW'(i)]    <= 8'd0;
          i               <= 5'(i + 5'd1);
        end
        snn_pkg::ST_U0: begin
          m6   <= m6_next;
          m5   <= m5_next;
          neg6 <= neg6_next;
          neg5 <= neg5_next;
        end
        snn_pkg::ST_U1: prod <= mul_p;
        snn_pkg::ST_U2: begin
          q6   <= prod[snn_pkg::SH6+22:snn_pkg::SH6];
          prod <= mul_p;
        end
        snn_pkg::ST_U3: begin
          vmem[vaddr]   <= v_upd;
          imem[iaddr]   <= in_upd;
          rflag[NW'(i)] <= flag_upd;
          rcnt[NW'(i)]  <= cnt_upd;
          i <= (i == 5'(n - 5'd1)) ? 5'd0 : 5'(i + 5'd1);
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  // Results only appear while a tick is in progress.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy) else $error("result strobe outside a tick");
  // The last report of a tick is followed by the firing walk, not another report.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last) |=> !result_strobe) else $error("report after last");
  // An accepted tick with active neurons starts reporting in the next cycle.
  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && action == snn_pkg::ACT_TICK && n != 5'd0) |=> (result_strobe && out_neuron == 4'd0))
    else $error("tick did not start reporting");
`endif

endmodule

// File: dv/spiking_neuron_network_tick_checker.sv
// Checker for the spiking network tick: predicts the voltage reports and scores them.
`timescale 1ns / 1ps

module spiking_neuron_network_tick_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         action,
  input  logic [3:0]         neuron_index,
  input  logic [1:0]         slot,
  input  logic [3:0]         target,
  input  logic               target_valid,
  input  logic               excitatory,
  input  logic [7:0]         stim_amount,
  input  logic               result_strobe,
  input  logic [3:0]         out_neuron,
  input  logic signed [11:0] voltage_out,
  input  logic               overflow,
  input  logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [snn_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [3:0]         neuron;
    logic signed [11:0] volt;
    logic               ovf;
    logic               lst;
  } report_t;

  localparam int NN = 16;
  localparam int FO = 4;

  report_t report_q[$];

  // Shadow copies of the configuration and the network state.
  logic [4:0]  cfg_active;
  logic [7:0]  cfg_refract;
  logic [10:0] cfg_thresh;
  int          volt_q8[NN];
  int          drive_q8[NN];
  logic        refr_flag[NN];
  logic [7:0]  refr_cnt[NN];
  logic [5:0]  syn[NN*FO];

  function automatic longint sat_q(longint x);
    if (x > 524287) return 524287;
    if (x < -524288) return -524288;
    return x;
  endfunction

  // Division rounded to nearest, ties away from zero.
  function automatic longint div_near(longint x, longint d);
    longint m;
    longint q;
    m = (x < 0) ? -x : x;
    q = (m + d / 2) / d;
    return (x < 0) ? -q : q;
  endfunction

  function automatic longint syn_weight(logic [5:0] s);
    return s[5] ? 64'sd1536 : -64'sd512;
  endfunction

  // Advance the network one tick and queue the expected reports.
  task automatic run_tick();
    int n;
    bit sent;
    longint r;
    longint v;
    longint num;
    report_t rep;
    n = (cfg_active > NN) ? NN : int'(cfg_active);
    for (int i = 0; i < n; i++) begin
      r = div_near(volt_q8[i], 256);
      rep.neuron = i[3:0];
      rep.volt = (r > 2047) ? 12'sd2047 : ((r < -2048) ? -12'sd2048 : 12'(r));
      rep.ovf = (r > 999);
      rep.lst = (i + 1 == n);
      report_q = {report_q, rep};
    end
    // Firing pass: outgoing synapses, else the first incoming source.
    for (int i = 0; i < n; i++) begin
      sent = 1'b0;
      if (longint'(volt_q8[i]) < longint'(cfg_thresh) * 256 || refr_flag[i]) continue;
      for (int k = 0; k < FO; k++) begin
        if (syn[i*FO+k][4]) begin
          drive_q8[syn[i*FO+k][3:0]] =
            int'(sat_q(drive_q8[syn[i*FO+k][3:0]] + syn_weight(syn[i*FO+k])));
          sent = 1'b1;
        end
      end
      for (int j = 0; j < n && !sent; j++) begin
        if (j == i) continue;
        for (int k = 0; k < FO && !sent; k++) begin
          if (syn[j*FO+k][4] && syn[j*FO+k][3:0] == i) begin
            drive_q8[j] = int'(sat_q(drive_q8[j] + syn_weight(syn[j*FO+k])));
            sent = 1'b1;
          end
        end
      end
      if (sent) begin
        v = volt_q8[i];
        refr_flag[i] = 1'b1;
        refr_cnt[i] = 8'd0;
        volt_q8[i] = int'(sat_q(v - div_near(v, 512) * 256));
      end
    end
    // Leaky integration of the input level.
    for (int i = 0; i < n; i++) begin
      v = volt_q8[i];
      num = -div_near(v, 256) * 256 + longint'(drive_q8[i]);
      volt_q8[i] = int'(sat_q(v + div_near(num * 5, 6)));
      drive_q8[i] = int'(sat_q((longint'(drive_q8[i]) * 4) / 5));
    end
    // Refractory timers.
    for (int i = 0; i < n; i++) begin
      if (refr_cnt[i] >= cfg_refract) begin
        refr_cnt[i] = 8'd0;
        refr_flag[i] = 1'b0;
      end
      if (refr_flag[i] && refr_cnt[i] < 255) refr_cnt[i]++;
    end
  endtask

  always @(posedge clk) begin
    report_t got;
    report_t exp;
    if (rst) begin
      fail_count = 0;
      cfg_active = snn_pkg::ACTIVE_RESET;
      cfg_refract = snn_pkg::REFRACT_RESET;
      cfg_thresh = snn_pkg::THRESH_RESET;
      for (int i = 0; i < NN; i++) begin
        volt_q8[i] = 0;
        drive_q8[i] = 0;
        refr_flag[i] = 1'b0;
        refr_cnt[i] = 8'd0;
      end
      for (int i = 0; i < NN*FO; i++) syn[i] = '0;
      report_q.delete();
    end else begin
      // Score a report against the oldest expectation.
      if (result_strobe) begin
        got = '{out_neuron, voltage_out, overflow, last};
        if (report_q.size() == 0) begin
          $error("unexpected report: neuron %0d voltage %0d", out_neuron, voltage_out);
          fail_count++;
        end else begin
          exp = report_q.pop_front();
          if (got.neuron !== exp.neuron) begin
            $error("out_neuron: expected %0d, actual %0d", exp.neuron, got.neuron);
            fail_count++;
          end
          if (got.volt !== exp.volt) begin
            $error("voltage_out: expected %0d, actual %0d", exp.volt, got.volt);
            fail_count++;
          end
          if (got.ovf !== exp.ovf) begin
            $error("overflow: expected %0d, actual %0d", exp.ovf, got.ovf);
            fail_count++;
          end
          if (got.lst !== exp.lst) begin
            $error("last: expected %0d, actual %0d", exp.lst, got.lst);
            fail_count++;
          end
        end
      end
      // Register writes.
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          snn_pkg::REG_ACTIVE:  cfg_active = pwdata[4:0];
          snn_pkg::REG_REFRACT: cfg_refract = pwdata[7:0];
          snn_pkg::REG_THRESH:  cfg_thresh = pwdata[10:0];
          default: ;
        endcase
      end
      // Accepted command transaction.
      if (start && !busy) begin
        case (action)
          snn_pkg::ACT_LOAD: syn[neuron_index*FO+slot] = {excitatory, target_valid, target};
          snn_pkg::ACT_STIM: volt_q8[neuron_index] =
            int'(sat_q(longint'(volt_q8[neuron_index]) + longint'(stim_amount) * 256));
          snn_pkg::ACT_TICK: run_tick();
          default: ;
        endcase
      end
    end
    pending = report_q.size();
  end

  // Empty final block: expectations still waiting when the run ends are not checked here.
  final begin
  end
endmodule

// File: dv/spiking_neuron_network_tick_top_tb.sv
// Testbench top for the spiking network tick: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module spiking_neuron_network_tick_top_tb;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] action = '0;
  logic [3:0] neuron_index = '0;
  logic [1:0] slot = '0;
  logic [3:0] target = '0;
  logic target_valid = 0;
  logic excitatory = 0;
  logic [7:0] stim_amount = '0;
  logic result_strobe;
  logic [3:0] out_neuron;
  logic signed [11:0] voltage_out;
  logic overflow;
  logic last;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [snn_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count;
  int pending;
  int burst_left = 0;

  always #10 clk = ~clk;

  spiking_neuron_network_tick_top dut (.*);

  spiking_neuron_network_tick_checker chk (.*);

  // One command transaction; returns after the accepting edge.
  task automatic send_cmd(logic [1:0] a, logic [3:0] idx, logic [1:0] sl, logic [3:0] tg,
                          logic tv, logic ex, logic [7:0] amt);
    @(negedge clk);
    start <= 1;
    action <= a;
    neuron_index <= idx;
    slot <= sl;
    target <= tg;
    target_valid <= tv;
    excitatory <= ex;
    stim_amount <= amt;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 0;
    end
  endtask

  // Bursty pacing between transactions.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 8);
      idle_cycles($urandom_range(1, 6));
    end
  endtask

  // Let every expected report arrive and the sequencer go idle.
  task automatic drain();
    idle_cycles(1);
    while (pending != 0 || busy) @(negedge clk);
    idle_cycles(4);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= snn_pkg::PADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic set_config(int act, int refr, int thr);
    drain();
    reg_write(snn_pkg::REG_ACTIVE, act);
    reg_write(snn_pkg::REG_REFRACT, refr);
    reg_write(snn_pkg::REG_THRESH, thr);
  endtask

  // Random transaction mix biased toward building and firing a network.
  task automatic random_cmd();
    int pick;
    logic [1:0] a;
    pick = $urandom_range(0, 99);
    if (pick < 30) a = snn_pkg::ACT_LOAD;
    else if (pick < 62) a = snn_pkg::ACT_STIM;
    else if (pick < 96) a = snn_pkg::ACT_TICK;
    else a = snn_pkg::ACT_IGNORE;
    send_cmd(a, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
             4'($urandom_range(0, 15)), ($urandom_range(0, 3) != 0), 1'($urandom),
             ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30)));
    pace();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: a small chain, sources search, saturation and odd cases.
    send_cmd(snn_pkg::ACT_LOAD, 0, 0, 1, 1, 1, 0);
    send_cmd(snn_pkg::ACT_LOAD, 1, 3, 2, 1, 0, 0);
    send_cmd(snn_pkg::ACT_LOAD, 2, 1, 3, 1, 1, 0);
    send_cmd(snn_pkg::ACT_LOAD, 15, 2, 15, 0, 1, 0);
    send_cmd(snn_pkg::ACT_LOAD, 4, 0, 15, 1, 1, 0);
    send_cmd(snn_pkg::ACT_STIM, 0, 0, 0, 0, 0, 20);
    send_cmd(snn_pkg::ACT_STIM, 3, 0, 0, 0, 0, 40);
    send_cmd(snn_pkg::ACT_STIM, 4, 0, 0, 0, 0, 12);
    send_cmd(snn_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0);
    send_cmd(snn_pkg::ACT_IGNORE, 5, 1, 5, 1, 1, 200);
    repeat (9) send_cmd(snn_pkg::ACT_STIM, 9, 0, 0, 0, 0, 255);
    send_cmd(snn_pkg::ACT_STIM, 15, 0, 0, 0, 0, 255);
    send_cmd(snn_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0);
    send_cmd(snn_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0);
    send_cmd(snn_pkg::ACT_STIM, 8, 0, 0, 0, 0, 0);
    send_cmd(snn_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0);

    // Random phases over several register settings.
    set_config(16, 0, 0);
    repeat (25) random_cmd();
    set_config(1, 255, 2047);
    repeat (20) random_cmd();
    set_config(5, 3, 20);
    repeat (25) random_cmd();
    drain();
    repeat (25) random_cmd();
    set_config(0, 1, 5);
    repeat (10) random_cmd();
    set_config(20, 1, 5);
    repeat (25) random_cmd();
    set_config(16, 2, 8);
    repeat (10) random_cmd();

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// File: sim.f
rtl/snn_pkg.sv
rtl/snn_ram.sv
rtl/spiking_neuron_network_tick_top.sv
dv/spiking_neuron_network_tick_checker.sv
dv/spiking_neuron_network_tick_top_tb.sv
